[sv/qvr_pkg.sv]
// Shared widths for the quaternion rotation datapath.
// No dependencies; used by qvr_numer, qvr_div and the top level.
package qvr_pkg;

    localparam int DATA_W = 32;   // Q16.16 field width
    localparam int NUM_W  = 100;  // rotated numerator, signed
    localparam int DEN_W  = 65;   // |q|^2, unsigned, at most 2^64
    localparam int MAG_W  = NUM_W - 1;
    localparam int Q_BITS = 33;   // quotient bits formed by the divider
    localparam int REM_W  = DEN_W + 1;
    localparam int NUM_STAGES = 4;
    localparam int DIV_STAGES = Q_BITS + 2;
    localparam int AXES = 3;

    typedef logic signed [NUM_W-1:0] t_num;
    typedef logic [DEN_W-1:0]        t_den;

    // control bits that travel through the divider
    typedef struct packed {
        logic vld;
        logic neg;
        logic ovf;
        logic zero;
    } t_div_ctl;

endpackage

[sv/qvr_numer.sv]
// Numerator and norm pipeline: four register stages of products and sums.
// Depends on qvr_pkg.
module qvr_numer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic signed [qvr_pkg::DATA_W-1:0]      i_w,
    input  logic signed [qvr_pkg::DATA_W-1:0]      i_u [qvr_pkg::AXES],
    input  logic signed [qvr_pkg::DATA_W-1:0]      i_p [qvr_pkg::AXES],
    output logic                                   o_vld,
    output qvr_pkg::t_num                          o_num [qvr_pkg::AXES],
    output qvr_pkg::t_den                          o_den
);

    // stage 1: 32x32 products
    logic               r_vld1;
    logic signed [63:0] r_ww;
    logic signed [63:0] r_uu [3];
    logic signed [63:0] r_dp [3];
    logic signed [63:0] r_ca [3];
    logic signed [63:0] r_cb [3];
    logic signed [31:0] r_w1;
    logic signed [31:0] r_u1 [3];
    logic signed [31:0] r_p1 [3];

    // stage 2: norm, scalar, dot and cross terms
    logic               r_vld2;
    logic [64:0]        r_norm2;
    logic signed [65:0] r_s;
    logic signed [65:0] r_d2;
    logic signed [32:0] r_w2;
    logic signed [64:0] r_c [3];
    logic signed [31:0] r_u2 [3];
    logic signed [31:0] r_p2 [3];

    // stage 3: split partial products of the wide terms
    logic               r_vld3;
    logic [64:0]        r_norm3;
    logic signed [65:0] r_sp_lo [3];
    logic signed [64:0] r_sp_hi [3];
    logic signed [65:0] r_du_lo [3];
    logic signed [64:0] r_du_hi [3];
    logic signed [66:0] r_wc_lo [3];
    logic signed [64:0] r_wc_hi [3];

    // stage 4: recombined numerators
    logic               r_vld4;
    logic [64:0]        r_norm4;
    qvr_pkg::t_num      r_num [3];

    logic signed [65:0] n_uu;
    logic signed [65:0] n_dot;
    logic signed [65:0] n_norm;

    always_comb begin
        n_uu   = 66'(r_uu[0]) + 66'(r_uu[1]) + 66'(r_uu[2]);
        n_dot  = 66'(r_dp[0]) + 66'(r_dp[1]) + 66'(r_dp[2]);
        n_norm = 66'(r_ww) + n_uu;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww    <= i_w * i_w;
            r_w1    <= i_w;
            r_norm2 <= n_norm[64:0];
            r_s     <= 66'(r_ww) - n_uu;
            r_d2    <= {n_dot[64:0], 1'b0};
            r_w2    <= {r_w1, 1'b0};
            r_norm3 <= r_norm2;
            r_norm4 <= r_norm3;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int A1 = (a + 1) % 3;
        localparam int A2 = (a + 2) % 3;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_uu[a] <= i_u[a] * i_u[a];
                r_dp[a] <= i_u[a] * i_p[a];
                r_ca[a] <= i_u[A1] * i_p[A2];
                r_cb[a] <= i_u[A2] * i_p[A1];
                r_u1[a] <= i_u[a];
                r_p1[a] <= i_p[a];

                r_c[a]  <= 65'(r_ca[a]) - 65'(r_cb[a]);
                r_u2[a] <= r_u1[a];
                r_p2[a] <= r_p1[a];

                r_sp_lo[a] <= $signed({1'b0, r_s[32:0]}) * r_p2[a];
                r_sp_hi[a] <= $signed(r_s[65:33]) * r_p2[a];
                r_du_lo[a] <= $signed({1'b0, r_d2[32:0]}) * r_u2[a];
                r_du_hi[a] <= $signed(r_d2[65:33]) * r_u2[a];
                r_wc_lo[a] <= $signed({1'b0, r_c[a][32:0]}) * r_w2;
                r_wc_hi[a] <= $signed(r_c[a][64:33]) * r_w2;

                r_num[a] <= (100'(r_sp_hi[a]) <<< 33) + 100'(r_sp_lo[a])
                          + (100'(r_du_hi[a]) <<< 33) + 100'(r_du_lo[a])
                          + (100'(r_wc_hi[a]) <<< 33) + 100'(r_wc_lo[a]);
            end
        end
        assign o_num[a] = r_num[a];
    end

    assign o_vld = r_vld4;
    assign o_den = r_norm4;

endmodule

[sv/qvr_div.sv]
// One divider lane: restoring division, one quotient bit per stage,
// rounding and saturation at the end. Depends on qvr_pkg.
module qvr_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  qvr_pkg::t_num                        i_num,
    input  qvr_pkg::t_den                        i_den,
    output logic                                 o_vld,
    output logic signed [qvr_pkg::DATA_W-1:0]    o_res,
    output logic                                 o_degen
);

    localparam int QB = qvr_pkg::Q_BITS;

    qvr_pkg::t_div_ctl               r_ctl [QB+1];
    logic [qvr_pkg::REM_W-1:0]       r_rem [QB+1];
    logic [QB-1:0]                   r_low [QB+1];
    logic [QB-1:0]                   r_q   [QB+1];
    qvr_pkg::t_den                   r_den [QB+1];

    logic                            r_vld_o;
    logic signed [qvr_pkg::DATA_W-1:0] r_res;
    logic                            r_degen;

    // entry: magnitude, sign and the early overflow test
    logic [qvr_pkg::NUM_W-1:0]       n_abs;
    logic [qvr_pkg::MAG_W-1:0]       n_mag;
    qvr_pkg::t_div_ctl               n_ctl0;

    always_comb begin
        n_abs       = i_num[qvr_pkg::NUM_W-1] ? 100'(-i_num) : i_num;
        n_mag       = n_abs[qvr_pkg::MAG_W-1:0];
        n_ctl0.vld  = i_vld;
        n_ctl0.neg  = i_num[qvr_pkg::NUM_W-1];
        // quotient would need more than QB bits
        n_ctl0.ovf  = {1'b0, n_mag} >= {2'b00, i_den, {QB{1'b0}}};
        n_ctl0.zero = (i_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].vld <= 1'b0;
        end else if (i_en) begin
            r_ctl[0].vld <= n_ctl0.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0].neg  <= n_ctl0.neg;
            r_ctl[0].ovf  <= n_ctl0.ovf;
            r_ctl[0].zero <= n_ctl0.zero;
            r_rem[0]      <= n_mag[qvr_pkg::MAG_W-1:QB];
            r_low[0]      <= n_mag[QB-1:0];
            r_q[0]        <= '0;
            r_den[0]      <= i_den;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [qvr_pkg::REM_W-1:0] n_shift;
        logic                      n_ge;
        always_comb begin
            n_shift = {r_rem[k-1][qvr_pkg::REM_W-2:0], r_low[k-1][QB-1]};
            n_ge    = n_shift >= {1'b0, r_den[k-1]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[k].vld <= r_ctl[k-1].vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[k].neg  <= r_ctl[k-1].neg;
                r_ctl[k].ovf  <= r_ctl[k-1].ovf;
                r_ctl[k].zero <= r_ctl[k-1].zero;
                r_rem[k]      <= n_ge ? n_shift - {1'b0, r_den[k-1]} : n_shift;
                r_low[k]      <= {r_low[k-1][QB-2:0], 1'b0};
                r_q[k]        <= {r_q[k-1][QB-2:0], n_ge};
                r_den[k]      <= r_den[k-1];
            end
        end
    end

    // round half away from zero, then saturate
    logic                       n_rnd;
    logic [QB:0]                n_qr;
    logic [QB:0]                n_lim;
    logic [qvr_pkg::DATA_W-1:0] n_m;
    logic [qvr_pkg::DATA_W-1:0] n_res;

    always_comb begin
        n_rnd = {r_rem[QB], 1'b0} >= {2'b00, r_den[QB]};
        n_qr  = {1'b0, r_q[QB]} + {{QB{1'b0}}, n_rnd};
        n_lim = r_ctl[QB].neg ? (34'd1 << 31) : ((34'd1 << 31) - 34'd1);
        if (r_ctl[QB].ovf || n_qr > n_lim) begin
            n_m = n_lim[qvr_pkg::DATA_W-1:0];
        end else begin
            n_m = n_qr[qvr_pkg::DATA_W-1:0];
        end
        n_res = r_ctl[QB].neg ? -n_m : n_m;
        if (r_ctl[QB].zero) begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld_o <= r_ctl[QB].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res   <= $signed(n_res);
            r_degen <= r_ctl[QB].zero;
        end
    end

    assign o_vld   = r_vld_o;
    assign o_res   = r_res;
    assign o_degen = r_degen;

endmodule

[sv/quaternion_vector_rotate.sv]
// Top level: rotates a Q16.16 point by a quaternion, q*p*conj(q)/|q|^2.
// Depends on qvr_pkg, qvr_numer and qvr_div.
//
// Input channel: i_valid / o_stall with quaternion and point fields.
// Output channel: o_valid / i_stall with the rotated point and the
// degenerate flag (zero quaternion; coordinates then read zero).
// A transfer happens on a clock edge with valid high and stall low.
// Throughput: one item per cycle while the receiver takes results.
// Pipeline: 4 product/sum stages followed by a
// 35-stage divider (entry, 33 quotient bits, round/saturate register).
// Each coordinate is rounded to nearest, ties away from zero, and
// saturated to the 32-bit signed range.
// The whole pipeline advances together; when a result sits at the
// output and i_stall is high, every stage holds and o_stall is raised,
// so nothing is dropped or repeated. Bubbles just flow through.
// Synchronous active-low reset clears all valid bits; no data is kept.
module quaternion_vector_rotate (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_quat_w,
    input  logic signed [31:0]   i_quat_x,
    input  logic signed [31:0]   i_quat_y,
    input  logic signed [31:0]   i_quat_z,
    input  logic signed [31:0]   i_point_x,
    input  logic signed [31:0]   i_point_y,
    input  logic signed [31:0]   i_point_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_rotated_x,
    output logic signed [31:0]   o_rotated_y,
    output logic signed [31:0]   o_rotated_z,
    output logic                 o_degenerate
);

    logic                          en;
    logic signed [31:0]            u [3];
    logic signed [31:0]            p [3];
    logic                          num_vld;
    qvr_pkg::t_num                 num [3];
    qvr_pkg::t_den                 den;
    logic                          div_vld [3];
    logic signed [31:0]            res [3];
    logic                          degen [3];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign u[0] = i_quat_x;
    assign u[1] = i_quat_y;
    assign u[2] = i_quat_z;
    assign p[0] = i_point_x;
    assign p[1] = i_point_y;
    assign p[2] = i_point_z;

    qvr_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_w     (i_quat_w),
        .i_u     (u),
        .i_p     (p),
        .o_vld   (num_vld),
        .o_num   (num),
        .o_den   (den)
    );

    for (genvar a = 0; a < 3; a++) begin : g_lane
        qvr_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (num_vld),
            .i_num   (num[a]),
            .i_den   (den),
            .o_vld   (div_vld[a]),
            .o_res   (res[a]),
            .o_degen (degen[a])
        );
    end

    // lanes run in lockstep, so their valid and flag bits always agree
    assign o_valid      = div_vld[0] && div_vld[1] && div_vld[2];
    assign o_degenerate = degen[0] && degen[1] && degen[2];
    assign o_rotated_x  = res[0];
    assign o_rotated_y  = res[1];
    assign o_rotated_z  = res[2];

endmodule

[sv/qvr_checker.sv]
// Port-level checks for quaternion_vector_rotate, bound to the top level.
// Depends only on the top level's ports.
module qvr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_rotated_x,
    input logic [31:0] o_rotated_y,
    input logic [31:0] o_rotated_z,
    input logic        o_degenerate
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rotated_x)
            && $stable(o_rotated_y) && $stable(o_rotated_z) && $stable(o_degenerate))
        else $error("stalled result changed");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_rotated_x == '0 && o_rotated_y == '0
            && o_rotated_z == '0)
        else $error("degenerate result with nonzero coordinates");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without an output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_rotated_x  (o_rotated_x),
    .o_rotated_y  (o_rotated_y),
    .o_rotated_z  (o_rotated_z),
    .o_degenerate (o_degenerate)
);

[tb/sv/tb_quaternion_vector_rotate.sv]
// Self-checking bench for quaternion_vector_rotate: random and directed rotations
// checked against an exact predictor held in a small scoreboard class.
// Depends on the RTL top level (and through it qvr_pkg).
`timescale 1ns / 100ps

class rotation_board;
    typedef struct {
        logic signed [31:0] rx, ry, rz;
        logic               degen;
    } t_rot;

    t_rot pending[$];
    int   errors;
    int   checked;
    int   degen_seen;
    int   sat_seen;

    // exact rounded, saturated quotient num/den, den > 0
    function automatic logic signed [31:0] div_round(logic signed [127:0] num,
                                                      logic signed [127:0] den);
        logic signed [127:0] mag, quo, rem;
        logic                neg;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if (2 * rem >= den) quo = quo + 1;
        if (neg) begin
            if (quo > 128'sd2147483648) quo = 128'sd2147483648;
            quo = -quo;
        end else if (quo > 128'sd2147483647) begin
            quo = 128'sd2147483647;
        end
        return quo[31:0];
    endfunction

    function void note_input(logic signed [31:0] qw, logic signed [31:0] qx,
                             logic signed [31:0] qy, logic signed [31:0] qz,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
        logic signed [127:0] w, x, y, z, vx, vy, vz, norm, s, d2, w2, nx, ny, nz;
        t_rot r;
        w = qw; x = qx; y = qy; z = qz; vx = px; vy = py; vz = pz;
        norm = w*w + x*x + y*y + z*z;
        r.degen = 0;
        if (norm == 0) begin
            r = '{0, 0, 0, 1};
        end else begin
            s  = w*w - (x*x + y*y + z*z);
            d2 = 2 * (x*vx + y*vy + z*vz);
            w2 = 2 * w;
            nx = s*vx + d2*x + w2*(y*vz - z*vy);
            ny = s*vy + d2*y + w2*(z*vx - x*vz);
            nz = s*vz + d2*z + w2*(x*vy - y*vx);
            r.rx = div_round(nx, norm);
            r.ry = div_round(ny, norm);
            r.rz = div_round(nz, norm);
        end
        pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    task check_result(logic signed [31:0] rx, logic signed [31:0] ry,
                      logic signed [31:0] rz, logic degen);
        t_rot e;
        if (pending.size() == 0) begin
            report("unexpected result", {31'b0, degen}, 0);
            return;
        end
        e = pending.pop_front();
        checked++;
        if (degen) degen_seen++;
        if (rx == 32'sh7fffffff || rx == 32'sh80000000) sat_seen++;
        if (rx !== e.rx) report("rotated_x", rx, e.rx);
        if (ry !== e.ry) report("rotated_y", ry, e.ry);
        if (rz !== e.rz) report("rotated_z", rz, e.rz);
        if (degen !== e.degen) report("degenerate", {31'b0, degen}, {31'b0, e.degen});
    endtask
endclass

module tb_quaternion_vector_rotate;
    localparam int LATENCY   = 39;
    localparam int MAX_CYCLE = 400000;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall, o_degenerate;
    logic signed [31:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic signed [31:0] i_point_x, i_point_y, i_point_z;
    logic signed [31:0] o_rotated_x, o_rotated_y, o_rotated_z;

    rotation_board board;
    int  cycle;
    bit  calm;      // no idling on either side
    bit  hold_out;  // long receiver hold-off request
    int  sent;

    quaternion_vector_rotate i_dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        board = new();
        i_rst_n = 0; i_valid = 0; i_stall = 0; calm = 0; hold_out = 0;
        {i_quat_w, i_quat_x, i_quat_y, i_quat_z} = '0;
        {i_point_x, i_point_y, i_point_z} = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        cycle++;
        if (cycle > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: stalls at random, plus one long hold-off
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                board.check_result(o_rotated_x, o_rotated_y, o_rotated_z, o_degenerate);
            if (hold_out) begin
                hold_out = 0;
                hold = 150;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1;
            end else begin
                i_stall <= !calm && $urandom_range(99) < 12;
            end
        end
    end

    function automatic logic [31:0] pick_field();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3, 4: return $urandom;
            5, 6: return $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
            default: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    task send_item(logic [31:0] qw, qx, qy, qz, px, py, pz);
        while (!calm && $urandom_range(99) < 12) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid   <= 1;
        i_quat_w  <= qw; i_quat_x <= qx; i_quat_y <= qy; i_quat_z <= qz;
        i_point_x <= px; i_point_y <= py; i_point_z <= pz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input(qw, qx, qy, qz, px, py, pz);
        sent++;
    endtask

    task drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] mx, mn, one;
        mx = 32'h7fff_ffff; mn = 32'h8000_0000; one = 32'h0001_0000;
        @(posedge i_rst_n);
        @(posedge i_clk);
        // directed: identity, zero quaternion, extremes, axis turns
        send_item(one, 0, 0, 0, one, 2*one, 3*one);
        send_item(0, 0, 0, 0, mx, mn, one);
        send_item(0, 0, 0, 0, 0, 0, 0);
        send_item(mx, mx, mx, mx, mx, mx, mx);
        send_item(mn, mn, mn, mn, mn, mn, mn);
        send_item(mn, mx, mn, mx, mx, mn, mx);
        send_item(0, one, 0, 0, one, one, one);
        send_item(0, 0, one, 0, one, one, one);
        send_item(0, 0, 0, one, one, one, one);
        send_item(one, one, 0, 0, mx, 0, mn);
        send_item(one, 0, one, 0, mn, mx, 0);
        send_item(one, 0, 0, one, 0, mn, mx);
        send_item(32'hffff_ffff, 0, 0, 0, 1, 32'hffff_ffff, 3);
        send_item(0, 1, 1, 0, 1, 0, 0);      // norm of two, exact quotient
        send_item(0, 1, 1, 0, 32'hffff_ffff, 0, 0);
        send_item(1, 0, 0, 0, mx, mn, 0);
        send_item(0, 0, 0, 1, mn, mn, mn);
        send_item(1, 1, 1, 1, 5, 7, 32'hffff_fff3);
        drain();
        for (int n = 0; n < 1800; n++) begin
            if (n == 300) calm = 1;
            if (n == 600) calm = 0;
            if (n == 900) hold_out = 1;  // sender keeps offering meanwhile
            if (n == 1200) drain();
            if ($urandom_range(19) == 0)
                send_item(0, 0, 0, 0, pick_field(), pick_field(), pick_field());
            else
                send_item(pick_field(), pick_field(), pick_field(), pick_field(),
                          pick_field(), pick_field(), pick_field());
        end
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d rotations, %0d zero quaternions, %0d saturated x results",
                 board.checked, board.degen_seen, board.sat_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[quaternion_vector_rotate.f]
sv/qvr_pkg.sv
sv/qvr_numer.sv
sv/qvr_div.sv
sv/quaternion_vector_rotate.sv
sv/qvr_checker.sv
tb/sv/tb_quaternion_vector_rotate.sv
